// File: design/tfe_pkg.sv
// Shared types, register codes and status codes of the TLV field extractor.
package tfe_pkg;

  // Configuration register indexes (byte address / 4)
  localparam logic [2:0] REG_TARGET_ID     = 3'd0;
  localparam logic [2:0] REG_MIN_VALUE_LEN = 3'd1;
  localparam logic [2:0] REG_MAX_VALUE_LEN = 3'd2;
  localparam logic [2:0] REG_LEGACY_FORMAT = 3'd3;
  localparam logic [2:0] REG_OPTIONAL      = 3'd4;
  localparam logic [2:0] REG_AREA_SIZE     = 3'd5;

  localparam int unsigned PADDR_W = 5;

  // Status codes
  localparam logic [2:0] ST_FOUND           = 3'd0;
  localparam logic [2:0] ST_ABSENT_OPTIONAL = 3'd1;
  localparam logic [2:0] ST_ABSENT_REQUIRED = 3'd2;
  localparam logic [2:0] ST_BAD_LENGTH      = 3'd3;
  localparam logic [2:0] ST_EXCEEDS_AREA    = 3'd4;
  localparam logic [2:0] ST_TRUNCATED       = 3'd5;

  // Header lengths in bytes
  localparam logic [15:0] HDR_LEN_LEGACY = 16'd2;

  typedef struct packed {
    logic [7:0]  target_id;
    logic [15:0] min_value_length;
    logic [15:0] max_value_length;
    logic        legacy_format;
    logic        optional_field;
    logic [15:0] area_size;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_status;
    logic [2:0] status;
    logic       end_of_run;
  } res_t;

  // Results produced by one input transaction: a value item, a status item, or both
  typedef struct packed {
    logic val_push;
    res_t val_item;
    logic stat_push;
    res_t stat_item;
  } push_t;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage

// File: design/tlv_field_extractor.sv
// TLV field extractor: one input byte per cycle. Each accepted byte updates
// the record walker in the same cycle and yields zero, one or two results
// (a value byte, and with the last byte a status item) into a 4-entry result
// queue that drains one result per cycle unless out_stall_i holds it. Input is
// taken at one byte per cycle as long as two queue entries are free; a last
// byte that is also a value byte produces two results into the queue.
// Configuration registers sit at byte addresses 0x00 to 0x14 in list order.
module tlv_field_extractor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tfe_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        last_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  out_byte_o,
  output logic                        is_status_o,
  output logic [2:0]                  status_o,
  output logic                        end_of_run_o
);
  import tfe_pkg::*;

  cfg_t  cfg;
  push_t push;
  res_t  out_item;
  logic  room;
  logic  in_accept;

  assign in_stall_o = ~room;
  assign in_accept  = in_valid_i & room;

  tfe_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tfe_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (in_accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (push)
  );

  tfe_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item)
  );

  // Drive result fields
  assign out_byte_o   = out_item.out_byte;
  assign is_status_o  = out_item.is_status;
  assign status_o     = out_item.status;
  assign end_of_run_o = out_item.end_of_run;

endmodule

// File: design/tfe_cfg_regs.sv
// APB-style configuration register file of the TLV field extractor.
module tfe_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tfe_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output tfe_pkg::cfg_t               cfg_o
);
  import tfe_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_o   = cfg_q;

  // Update the addressed register on the access phase of a write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_id        <= 8'd0;
      cfg_q.min_value_length <= 16'd0;
      cfg_q.max_value_length <= 16'hFFFF;
      cfg_q.legacy_format    <= 1'b0;
      cfg_q.optional_field   <= 1'b0;
      cfg_q.area_size        <= 16'hFFFF;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TARGET_ID:     cfg_q.target_id        <= pwdata[7:0];
        REG_MIN_VALUE_LEN: cfg_q.min_value_length <= pwdata[15:0];
        REG_MAX_VALUE_LEN: cfg_q.max_value_length <= pwdata[15:0];
        REG_LEGACY_FORMAT: cfg_q.legacy_format    <= pwdata[0];
        REG_OPTIONAL:      cfg_q.optional_field   <= pwdata[0];
        REG_AREA_SIZE:     cfg_q.area_size        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_TARGET_ID:     prdata = {24'd0, cfg_q.target_id};
      REG_MIN_VALUE_LEN: prdata = {16'd0, cfg_q.min_value_length};
      REG_MAX_VALUE_LEN: prdata = {16'd0, cfg_q.max_value_length};
      REG_LEGACY_FORMAT: prdata = {31'd0, cfg_q.legacy_format};
      REG_OPTIONAL:      prdata = {31'd0, cfg_q.optional_field};
      REG_AREA_SIZE:     prdata = {16'd0, cfg_q.area_size};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

// File: design/tfe_parser.sv
// Record walker: tracks header and value position and produces results per byte.
module tfe_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tfe_pkg::cfg_t  cfg_i,
  input  logic           accept_i,
  input  logic [7:0]     data_byte_i,
  input  logic           last_byte_i,
  output tfe_pkg::push_t push_o
);
  import tfe_pkg::*;

  logic [15:0] pos_q, pos_d;
  logic [1:0]  hidx_q, hidx_d;
  logic [7:0]  rid_q, rid_d;
  logic [15:0] vrem_q, vrem_d;
  logic        match_q, match_d;
  logic        copy_q, copy_d;
  logic [2:0]  err_q, err_d;

  logic        active;
  logic        hdr_done;
  logic [15:0] vlen;
  logic [17:0] rec_end;
  logic [2:0]  st_code;

  assign active  = (err_q == ST_FOUND) && !(match_q && !copy_q);
  assign rec_end = {2'b00, pos_q} + {2'b00, vlen} + 18'd1;

  // Next state for the byte at hand
  always_comb begin
    pos_d    = (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;
    hidx_d   = hidx_q;
    rid_d    = rid_q;
    vrem_d   = vrem_q;
    match_d  = match_q;
    copy_d   = copy_q;
    err_d    = err_q;
    hdr_done = 1'b0;
    vlen     = 16'd0;
    push_o   = '0;

    if (active) begin
      if (hidx_q == 2'd0 && vrem_q != 16'd0) begin
        // Copy or skip one value byte
        if (copy_q) begin
          push_o.val_push          = 1'b1;
          push_o.val_item.out_byte = data_byte_i;
        end
        vrem_d = vrem_q - 16'd1;
        if (vrem_d == 16'd0) begin
          copy_d = 1'b0;
        end
      end else if (cfg_i.legacy_format) begin
        if (hidx_q == 2'd0) begin
          vrem_d = {8'd0, data_byte_i};
          hidx_d = 2'd1;
        end else begin
          rid_d    = data_byte_i;
          vlen     = (vrem_q > HDR_LEN_LEGACY) ? vrem_q - HDR_LEN_LEGACY : 16'd0;
          hdr_done = 1'b1;
        end
      end else begin
        case (hidx_q)
          2'd0: begin
            rid_d  = data_byte_i;
            vrem_d = 16'd0;
            hidx_d = 2'd1;
          end
          2'd1: begin
            vrem_d = {data_byte_i, 8'd0};
            hidx_d = 2'd2;
          end
          default: begin
            vlen     = {vrem_q[15:8], data_byte_i};
            hdr_done = 1'b1;
          end
        endcase
      end
    end

    // Check a completed header against the target
    if (hdr_done) begin
      hidx_d = 2'd0;
      if (rid_d == cfg_i.target_id) begin
        match_d = 1'b1;
        vrem_d  = 16'd0;
        if (vlen < cfg_i.min_value_length || vlen > cfg_i.max_value_length) begin
          err_d = ST_BAD_LENGTH;
        end else if (rec_end > {2'b00, cfg_i.area_size}) begin
          err_d = ST_EXCEEDS_AREA;
        end else if (vlen != 16'd0) begin
          copy_d = 1'b1;
          vrem_d = vlen;
        end
      end else begin
        vrem_d = vlen;
      end
    end

    // Close the run on the last byte
    if (err_d != ST_FOUND) begin
      st_code = err_d;
    end else if (match_d) begin
      st_code = copy_d ? ST_TRUNCATED : ST_FOUND;
    end else if (!cfg_i.legacy_format && hidx_d != 2'd0 && rid_d == cfg_i.target_id) begin
      st_code = ST_TRUNCATED;
    end else begin
      st_code = cfg_i.optional_field ? ST_ABSENT_OPTIONAL : ST_ABSENT_REQUIRED;
    end

    if (last_byte_i) begin
      push_o.stat_push            = 1'b1;
      push_o.stat_item.is_status  = 1'b1;
      push_o.stat_item.status     = st_code;
      push_o.stat_item.end_of_run = 1'b1;
      pos_d   = 16'd0;
      hidx_d  = 2'd0;
      rid_d   = 8'd0;
      vrem_d  = 16'd0;
      match_d = 1'b0;
      copy_d  = 1'b0;
      err_d   = ST_FOUND;
    end

    if (!accept_i) begin
      push_o = '0;
    end
  end

  // Advance the walker on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 16'd0;
      hidx_q  <= 2'd0;
      rid_q   <= 8'd0;
      vrem_q  <= 16'd0;
      match_q <= 1'b0;
      copy_q  <= 1'b0;
      err_q   <= ST_FOUND;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      hidx_q  <= hidx_d;
      rid_q   <= rid_d;
      vrem_q  <= vrem_d;
      match_q <= match_d;
      copy_q  <= copy_d;
      err_q   <= err_d;
    end
  end

endmodule

// File: design/tfe_out_queue.sv
// Result queue: takes up to two results per cycle, drains one per cycle when not stalled.
module tfe_out_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tfe_pkg::push_t push_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tfe_pkg::res_t  out_item_o
);
  import tfe_pkg::*;

  res_t              mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_q, rp_q;
  logic [QUEUE_AW:0]   cnt_q;
  logic                pop;
  logic [QUEUE_AW-1:0] stat_wp;
  logic [1:0]          n_push;

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rp_q];
  assign pop         = out_valid_o & ~out_stall_i;
  // Accept new input only while two entries are free
  assign room_o      = (cnt_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));
  assign stat_wp     = wp_q + QUEUE_AW'(push_i.val_push);
  assign n_push      = {1'b0, push_i.val_push} + {1'b0, push_i.stat_push};

  // Store results, value item ahead of status item
  always_ff @(posedge clk_i) begin
    if (push_i.val_push) begin
      mem_q[wp_q] <= push_i.val_item;
    end
    if (push_i.stat_push) begin
      mem_q[stat_wp] <= push_i.stat_item;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + QUEUE_AW'(n_push);
      rp_q  <= rp_q + QUEUE_AW'(pop);
      cnt_q <= cnt_q + (QUEUE_AW + 1)'(n_push) - (QUEUE_AW + 1)'(pop);
    end
  end

endmodule
